### rtl/adpcm_bd_pkg.sv
// Package with the shared widths, register indexes and defaults of the ADPCM block decoder.
`timescale 1ns / 1ps

package adpcm_bd_pkg;

    // Default number of channels that can take turns.
    localparam int DEFAULT_MAX_CHANNELS = 2;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int PCM_W   = 16;
    localparam int SCALE_W = 16;
    localparam int NIB_W   = 4;

    // Configuration register widths.
    localparam int COEF_RECENT_W = 14;
    localparam int COEF_OLDER_W  = 13;
    localparam int BLOCK_BYTES_W = 8;
    localparam int CHAN_USED_W   = 2;
    localparam int CFG_DATA_W    = 14;
    localparam int CFG_IDX_W     = 2;

    // Arithmetic widths: scaled nibble, prediction products, sum after the shift.
    localparam int TERM_W  = 21;
    localparam int PROD_W  = 32;
    localparam int FRAC_W  = 12;
    localparam int PRED_W  = PROD_W - FRAC_W;
    localparam int TOTAL_W = 22;

    // Reset values and limits.
    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RST = 8'd18;
    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_MIN = 8'd3;
    localparam logic [CHAN_USED_W-1:0]   CHAN_USED_RST   = 2'd1;
    localparam logic signed [PCM_W-1:0]  PCM_MAX         = 16'sd32767;
    localparam logic signed [PCM_W-1:0]  PCM_MIN         = -16'sd32768;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_RECENT = 2'd0,
        CFG_COEF_OLDER  = 2'd1,
        CFG_BLOCK_BYTES = 2'd2,
        CFG_CHAN_USED   = 2'd3
    } t_cfg_idx;

    // Saturate a widened sum to the 16-bit sample range.
    function automatic logic signed [PCM_W-1:0] sat_pcm(input logic signed [TOTAL_W-1:0] v);
        logic signed [PCM_W-1:0] r;
        if (v > TOTAL_W'(PCM_MAX)) begin
            r = PCM_MAX;
        end else if (v < TOTAL_W'(PCM_MIN)) begin
            r = PCM_MIN;
        end else begin
            r = v[PCM_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/adpcm_block_decoder_2tap.sv
// Top level of the two-tap 4-bit ADPCM block decoder.
`timescale 1ns / 1ps

// The decoder takes a compressed stream one byte per slave transaction, cut into
// blocks of block_bytes bytes (values below three act as three) that take turns
// among channels_used channels (zero acts as one, values above MAX_CHANNELS act as
// MAX_CHANNELS). The first two bytes of every block load a big-endian scale and
// give no result; every later byte gives two master transactions, the high nibble
// first, the second one marked by tlast and both tagged with the channel in tuser.
// Each sample is the sign-extended nibble times the scale plus
// (coef_recent * newest + coef_older * older) shifted right arithmetically by 12,
// saturated to 16 bits. Setting tuser on an input byte clears the histories, the
// block position, the channel and the held scale before that byte is taken.
// A data byte stays in the work stage for both nibbles, decoded in turn as the
// second sample's prediction needs the first from the single multiply, add and
// saturate datapath; a scale byte gives no result. A new byte is taken as the work
// stage finishes the last one. A two-entry output queue between the datapath and
// the master side lets the slave side keep taking bytes while a finished sample
// waits and the queue has room. A byte's first sample passes the work stage
// register, then the queue. The user writes configuration through the plain write
// port only while no transaction is in flight; the block does not enforce this.
module adpcm_block_decoder_2tap
    import adpcm_bd_pkg::*;
#(
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Slave side: compressed bytes.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_axis_tuser,   // [0] restart
    // Master side: decoded samples.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PCM_W-1:0]      m_axis_tdata,   // [15:0] pcm_sample
    output logic [0:0]            m_axis_tuser,   // [0] channel_tag
    output logic                  m_axis_tlast    // last_of_byte
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W = $clog2(MAX_CHANNELS + 1) + 1;

    // Configuration registers.
    logic [COEF_RECENT_W-1:0]        r_coef_recent;
    logic signed [COEF_OLDER_W-1:0]  r_coef_older;
    logic [BLOCK_BYTES_W-1:0]        r_block_bytes;
    logic [CHAN_USED_W-1:0]          r_chan_used;

    // Stream position, owned by the slave side.
    logic [BYTE_W-1:0]  r_pos, n_pos;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic [SCALE_W-1:0] r_scale, n_scale;

    // Work stage: one byte being decoded.
    logic               r_w_valid;
    logic               r_w_data;
    logic               r_w_clr;
    logic               r_w_phase;
    logic [BYTE_W-1:0]  r_w_byte;
    logic [CH_W-1:0]    r_w_ch;
    logic [SCALE_W-1:0] r_w_scale;

    // Per-channel history.
    logic signed [PCM_W-1:0] r_hist_new [MAX_CHANNELS];
    logic signed [PCM_W-1:0] r_hist_old [MAX_CHANNELS];

    // Two-entry output queue.
    logic [PCM_W-1:0] r_q_pcm  [2];
    logic             r_q_tag  [2];
    logic             r_q_last [2];
    logic             r_q_rd;
    logic             r_q_wr;
    logic [1:0]       r_q_cnt;

    logic in_acc;
    logic q_pop;
    logic q_room;
    logic push;
    logic work_done;

    // Slave-side decode of the position.
    logic [BYTE_W-1:0]        pos_base;
    logic [CH_W-1:0]          ch_base;
    logic [CH_W-1:0]          ch_eff;
    logic [SCALE_W-1:0]       scale_base;
    logic [BLOCK_BYTES_W-1:0] bb_eff;
    logic [NCH_W-1:0]         nch_eff;
    logic [BYTE_W:0]          pos_inc;
    logic                     is_data;

    always_comb begin
        pos_base   = s_axis_tuser[0] ? '0 : r_pos;
        ch_base    = s_axis_tuser[0] ? '0 : r_ch;
        scale_base = s_axis_tuser[0] ? '0 : r_scale;
        ch_eff     = (int'(ch_base) >= MAX_CHANNELS) ? '0 : ch_base;
        bb_eff     = (r_block_bytes < BLOCK_BYTES_MIN) ? BLOCK_BYTES_MIN : r_block_bytes;
        if (r_chan_used == '0) begin
            nch_eff = NCH_W'(1);
        end else if (int'(r_chan_used) > MAX_CHANNELS) begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_eff = NCH_W'(r_chan_used);
        end
        pos_inc = {1'b0, pos_base} + (BYTE_W + 1)'(1);
        is_data = (pos_base != BYTE_W'(0)) && (pos_base != BYTE_W'(1));

        // The first byte of a block loads the upper half of the scale, the second the lower half.
        n_scale = scale_base;
        if (pos_base == BYTE_W'(0)) begin
            n_scale = {s_axis_tdata, scale_base[BYTE_W-1:0]};
        end else if (pos_base == BYTE_W'(1)) begin
            n_scale = {scale_base[SCALE_W-1:BYTE_W], s_axis_tdata};
        end

        // At the end of a block move on to the next channel, wrapping to zero; else step the position.
        if (pos_inc >= {1'b0, bb_eff}) begin
            n_pos = '0;
            if ((int'(ch_eff) + 1) >= int'(nch_eff)) begin
                n_ch = '0;
            end else begin
                n_ch = CH_W'(int'(ch_eff) + 1);
            end
        end else begin
            n_pos = pos_inc[BYTE_W-1:0];
            n_ch  = ch_eff;
        end
    end

    // Sample datapath: one nibble per cycle while the output queue has room.
    logic signed [NIB_W-1:0]   nib;
    logic signed [PCM_W-1:0]   h_new;
    logic signed [PCM_W-1:0]   h_old;
    logic signed [TERM_W-1:0]  term;
    logic signed [PROD_W-1:0]  prod_recent;
    logic signed [PROD_W-1:0]  prod_older;
    logic signed [PROD_W-1:0]  pred_sum;
    logic signed [PRED_W-1:0]  pred;
    logic signed [TOTAL_W-1:0] total;
    logic signed [PCM_W-1:0]   sample;

    always_comb begin
        nib         = r_w_phase ? r_w_byte[NIB_W-1:0] : r_w_byte[BYTE_W-1:NIB_W];
        h_new       = r_hist_new[r_w_ch];
        h_old       = r_hist_old[r_w_ch];
        term        = TERM_W'(nib) * TERM_W'($signed({1'b0, r_w_scale}));
        prod_recent = PROD_W'($signed({1'b0, r_coef_recent})) * PROD_W'(h_new);
        prod_older  = PROD_W'(r_coef_older) * PROD_W'(h_old);
        pred_sum    = prod_recent + prod_older;
        pred        = pred_sum[PROD_W-1:FRAC_W];
        total       = TOTAL_W'(term) + TOTAL_W'(pred);
        sample      = sat_pcm(total);
    end

    // Handshakes.
    assign q_pop         = m_axis_tvalid && m_axis_tready;
    assign q_room        = (r_q_cnt != 2'd2) || q_pop;
    assign push          = r_w_valid && r_w_data && q_room;
    assign work_done     = r_w_valid && (!r_w_data || (r_w_phase && q_room));
    assign s_axis_tready = !r_w_valid || work_done;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid   = (r_q_cnt != 2'd0);
    assign m_axis_tdata    = r_q_pcm[r_q_rd];
    assign m_axis_tuser[0] = r_q_tag[r_q_rd];
    assign m_axis_tlast    = r_q_last[r_q_rd];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_recent <= '0;
            r_coef_older  <= '0;
            r_block_bytes <= BLOCK_BYTES_RST;
            r_chan_used   <= CHAN_USED_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_RECENT: r_coef_recent <= i_cfg_data[COEF_RECENT_W-1:0];
                CFG_COEF_OLDER:  r_coef_older  <= $signed(i_cfg_data[COEF_OLDER_W-1:0]);
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[BLOCK_BYTES_W-1:0];
                CFG_CHAN_USED:   r_chan_used   <= i_cfg_data[CHAN_USED_W-1:0];
                default: ;
            endcase
        end
    end

    // Stream position and the work stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_ch      <= '0;
            r_scale   <= '0;
            r_w_valid <= 1'b0;
            r_w_data  <= 1'b0;
            r_w_clr   <= 1'b0;
            r_w_phase <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pos     <= n_pos;
                r_ch      <= n_ch;
                r_scale   <= n_scale;
                r_w_valid <= 1'b1;
                r_w_data  <= is_data;
                r_w_clr   <= s_axis_tuser[0];
                r_w_phase <= 1'b0;
                r_w_byte  <= s_axis_tdata;
                r_w_ch    <= ch_eff;
                r_w_scale <= n_scale;
            end else if (work_done) begin
                r_w_valid <= 1'b0;
            end else if (push) begin
                r_w_phase <= 1'b1;
            end
        end
    end

    // History: cleared for all channels at once by a restart byte, updated by every sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_hist_new[i] <= '0;
                r_hist_old[i] <= '0;
            end
        end else if (r_w_valid && r_w_clr) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_hist_new[i] <= '0;
                r_hist_old[i] <= '0;
            end
        end else if (push) begin
            r_hist_new[r_w_ch] <= sample;
            r_hist_old[r_w_ch] <= h_new;
        end
    end

    // Output queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_rd  <= 1'b0;
            r_q_wr  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q_wr <= !r_q_wr;
            end
            if (q_pop) begin
                r_q_rd <= !r_q_rd;
            end
            if (push && !q_pop) begin
                r_q_cnt <= r_q_cnt + 2'd1;
            end else if (q_pop && !push) begin
                r_q_cnt <= r_q_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_pcm[r_q_wr]  <= sample;
            r_q_tag[r_q_wr]  <= r_w_ch[0];
            r_q_last[r_q_wr] <= r_w_phase;
        end
    end

    // The queue never holds more than its two entries.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("output queue count out of range");

    // A scale byte never produces a sample.
    a_scale_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w_valid && !r_w_data) |-> !push)
        else $error("scale byte produced a sample");

    // After the high-nibble sample the same byte stays for its low nibble.
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !r_w_phase) |=> (r_w_valid && r_w_data && r_w_phase))
        else $error("low-nibble sample lost");

    // A restart byte leaves the block on its second byte in channel zero.
    a_restart_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser[0]) |=> (r_pos == BYTE_W'(1) && r_ch == '0))
        else $error("restart did not reset the position");

    // The stored channel stays within the channels provided.
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ch) < MAX_CHANNELS)
        else $error("channel out of range");

endmodule

### sim/tb_adpcm_block_decoder_2tap.sv
// Self-checking testbench for the two-tap 4-bit ADPCM block decoder.
`timescale 1ns / 1ps

// The bench feeds the decoder a compressed byte stream on the slave side and
// collects the decoded samples on the master side. A shadow decoder, written
// here from the block's specification, follows every accepted slave
// transaction and queues the samples it should cause. Every master transaction
// is compared field by field with the oldest queued sample.
//
// The run has three parts:
//   * a short directed table covering the reset state, the sample extremes,
//     the coefficient and register extremes, a restart, a short block, channel
//     counts of zero and above the maximum, a block size shrunk in the middle
//     of a block and a channel count dropped below the current channel;
//   * random phases, each with fresh register settings and random bytes;
//   * a calm tail in which neither side idles.
// Registers are only written once the decoder has gone quiet, that is when no
// sample is outstanding and a few further cycles have passed. Both handshakes
// idle in random bursts so that pauses land on scale bytes and data bytes alike.
module tb_adpcm_block_decoder_2tap;
    import adpcm_bd_pkg::*;

    localparam int NUM_CH          = DEFAULT_MAX_CHANNELS;
    localparam int RAND_ITEMS      = 1200;
    localparam int CALM_ITEMS      = 150;
    // A scale byte may still sit in the work stage when the last sample has
    // left, so a settling wait is allowed before a register write or the end.
    localparam int SETTLE_CYCLES   = 10;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_CYCLES = 400;

    // One decoded sample as it should appear on the master side.
    typedef struct packed {
        logic signed [PCM_W-1:0] pcm;
        logic                    chan;
        logic                    last;
    } t_pcm_result;

    // Samples typed in by hand for a directed row; unused when known is clear.
    typedef struct {
        bit                      known;
        logic signed [PCM_W-1:0] hi;
        logic signed [PCM_W-1:0] lo;
    } t_known_pair;

    // Directed table. For ROW_BYTE f0 is the byte and f1 the restart flag;
    // ROW_KNOWN adds the high and low nibble samples in f2 and f3; ROW_CFG
    // carries coef_recent, coef_older, block_bytes and channels_used in f0..f3.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_KNOWN,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        int        f0;
        int        f1;
        int        f2;
        int        f3;
    } t_dir_row;

    localparam int DIR_ROWS = 32;

    t_dir_row dir_tab [DIR_ROWS] = '{
        // Reset settings: zero coefficients, 18-byte blocks, one channel.
        // A zero scale gives silence whatever the nibbles are.
        '{ROW_BYTE,  'h00, 0, 0, 0},
        '{ROW_BYTE,  'h00, 0, 0, 0},
        '{ROW_KNOWN, 'h78, 0, 0, 0},
        // Restart in the middle of a block, then a scale of 0x7FFF drives the
        // extreme nibbles straight into saturation at both ends.
        '{ROW_BYTE,  'h7F, 1, 0, 0},
        '{ROW_BYTE,  'hFF, 0, 0, 0},
        '{ROW_KNOWN, 'h78, 0, 32767, -32768},
        '{ROW_KNOWN, 'h87, 0, -32768, 32767},
        // Recent coefficient 8192, most negative older coefficient, shortest legal block and two channels.
        '{ROW_CFG,   8192, -4096, 3, 2},
        '{ROW_BYTE,  'hFF, 1, 0, 0},
        '{ROW_BYTE,  'hFF, 0, 0, 0},
        '{ROW_BYTE,  'h77, 0, 0, 0},
        '{ROW_BYTE,  'h12, 0, 0, 0},
        '{ROW_BYTE,  'h34, 0, 0, 0},
        '{ROW_BYTE,  'h9E, 0, 0, 0},
        // A block size of zero acts as three and a channel count of zero as one.
        '{ROW_CFG,   0, 0, 0, 0},
        '{ROW_BYTE,  'h40, 1, 0, 0},
        '{ROW_BYTE,  'h00, 0, 0, 0},
        '{ROW_BYTE,  'h11, 0, 0, 0},
        // Longest block and a channel count above the maximum.
        '{ROW_CFG,   4096, -2048, 255, 3},
        '{ROW_BYTE,  'h10, 1, 0, 0},
        '{ROW_BYTE,  'h00, 0, 0, 0},
        '{ROW_BYTE,  'hC4, 0, 0, 0},
        '{ROW_BYTE,  'h3B, 0, 0, 0},
        // The block shrinks under the current position: the next byte ends it.
        '{ROW_CFG,   4096, -2048, 3, 3},
        '{ROW_BYTE,  'h5D, 0, 0, 0},
        '{ROW_BYTE,  'h02, 0, 0, 0},
        '{ROW_BYTE,  'h00, 0, 0, 0},
        // The count drops below the current channel: it wraps to channel 0
        // once the running block is over.
        '{ROW_CFG,   4096, -2048, 3, 1},
        '{ROW_BYTE,  'h6E, 0, 0, 0},
        '{ROW_BYTE,  'h01, 0, 0, 0},
        '{ROW_BYTE,  'h00, 0, 0, 0},
        '{ROW_BYTE,  'hF1, 0, 0, 0}
    };

    // Clock, reset and every decoder input start from a known value.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = CFG_COEF_RECENT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;   // [7:0] data_byte
    logic [0:0]            s_axis_tuser  = '0;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PCM_W-1:0]      m_axis_tdata;         // [15:0] pcm_sample
    logic [0:0]            m_axis_tuser;         // [0] channel_tag
    logic                  m_axis_tlast;         // last_of_byte

    // Idling controls, set per phase by the stimulus process.
    bit calm_tail = 1'b0;
    bit gaps_on   = 1'b1;
    int stall_pct = 30;
    int stall_left = 0;
    int err_count = 0;
    int idle_cycles = 0;

    t_pcm_result samples_due [$];
    t_known_pair known_due [$];

    // Shadow copy of the registers and of the stream state.
    logic [COEF_RECENT_W-1:0]        coef_recent_m;
    logic signed [COEF_OLDER_W-1:0]  coef_older_m;
    logic [BLOCK_BYTES_W-1:0]        block_bytes_m;
    logic [CHAN_USED_W-1:0]          chan_used_m;
    logic [BLOCK_BYTES_W-1:0]        pos_m;
    logic [0:0]                      cur_chan_m;
    logic [SCALE_W-1:0]              scale_m;
    logic signed [PCM_W-1:0]         hist_new_m [NUM_CH];
    logic signed [PCM_W-1:0]         hist_old_m [NUM_CH];

    adpcm_block_decoder_2tap #(
        .MAX_CHANNELS(NUM_CH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Clears the histories, the block position, the channel and the scale.
    function automatic void clear_stream();
        pos_m      = '0;
        cur_chan_m = '0;
        scale_m    = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            hist_new_m[i] = '0;
            hist_old_m[i] = '0;
        end
    endfunction

    // One nibble: scaled code plus the floored two-tap prediction, saturated,
    // then pushed into the channel's history.
    function automatic logic signed [PCM_W-1:0] next_pcm(input int ch,
                                                         input logic [NIB_W-1:0] nib);
        logic signed [NIB_W-1:0] code;
        longint                  acc;
        longint                  sum;
        code = nib;
        acc  = longint'(coef_recent_m) * longint'(hist_new_m[ch])
             + longint'(coef_older_m) * longint'(hist_old_m[ch]);
        sum  = longint'(code) * longint'(scale_m) + (acc >>> FRAC_W);
        if (sum > longint'(PCM_MAX)) begin
            sum = longint'(PCM_MAX);
        end else if (sum < longint'(PCM_MIN)) begin
            sum = longint'(PCM_MIN);
        end
        hist_old_m[ch] = hist_new_m[ch];
        hist_new_m[ch] = PCM_W'(sum);
        return PCM_W'(sum);
    endfunction

    // Takes one byte into the shadow decoder; returns the number of samples.
    function automatic int decode_byte(input logic [BYTE_W-1:0] din, input logic clear,
                                       output t_pcm_result hi_r, output t_pcm_result lo_r);
        int span;
        int nch;
        int ch;
        int n;
        span = (block_bytes_m < BLOCK_BYTES_MIN) ? int'(BLOCK_BYTES_MIN) : int'(block_bytes_m);
        nch  = (chan_used_m == 0) ? 1 : int'(chan_used_m);
        if (nch > NUM_CH) begin
            nch = NUM_CH;
        end
        n    = 0;
        hi_r = '0;
        lo_r = '0;
        if (clear) begin
            clear_stream();
        end
        ch = int'(cur_chan_m);
        if (ch >= NUM_CH) begin
            ch = 0;
        end
        if (pos_m == 0) begin
            scale_m[15:8] = din;
        end else if (pos_m == 1) begin
            scale_m[7:0] = din;
        end else begin
            hi_r.pcm  = next_pcm(ch, din[7:4]);
            hi_r.chan = ch[0];
            hi_r.last = 1'b0;
            lo_r.pcm  = next_pcm(ch, din[3:0]);
            lo_r.chan = ch[0];
            lo_r.last = 1'b1;
            n = 2;
        end
        // A position at or past the last byte of the current size ends the block.
        if (int'(pos_m) + 1 >= span) begin
            pos_m = '0;
            ch++;
            if (ch >= nch) begin
                ch = 0;
            end
            cur_chan_m = 1'(ch);
        end else begin
            pos_m = pos_m + 1'b1;
        end
        return n;
    endfunction

    // Monitor: samples both handshakes and the write port at each rising edge,
    // using the values that held just before the edge. The shadow decoder
    // lives entirely in this process.
    always @(posedge i_clk) begin : monitor
        t_pcm_result hi_r;
        t_pcm_result lo_r;
        t_pcm_result want;
        t_known_pair kp;
        int          n;
        if (!i_rst_n) begin
            coef_recent_m = '0;
            coef_older_m  = '0;
            block_bytes_m = BLOCK_BYTES_RST;
            chan_used_m   = CHAN_USED_RST;
            clear_stream();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (samples_due.size() == 0) begin
                    report_mismatch($sformatf("sample %0d on channel %0d with none expected",
                                              $signed(m_axis_tdata), m_axis_tuser[0]));
                end else begin
                    want = samples_due.pop_front();
                    if (m_axis_tdata !== want.pcm) begin
                        report_mismatch($sformatf("pcm_sample: got %0d, expected %0d",
                                                  $signed(m_axis_tdata), want.pcm));
                    end
                    if (m_axis_tuser[0] !== want.chan) begin
                        report_mismatch($sformatf("channel_tag: got %0b, expected %0b",
                                                  m_axis_tuser[0], want.chan));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("last_of_byte: got %0b, expected %0b",
                                                  m_axis_tlast, want.last));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COEF_RECENT: coef_recent_m = i_cfg_data[COEF_RECENT_W-1:0];
                    CFG_COEF_OLDER:  coef_older_m  = i_cfg_data[COEF_OLDER_W-1:0];
                    CFG_BLOCK_BYTES: block_bytes_m = i_cfg_data[BLOCK_BYTES_W-1:0];
                    CFG_CHAN_USED:   chan_used_m   = i_cfg_data[CHAN_USED_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                kp = '{known: 1'b0, hi: '0, lo: '0};
                if (known_due.size() != 0) begin
                    kp = known_due.pop_front();
                end
                n = decode_byte(s_axis_tdata, s_axis_tuser[0], hi_r, lo_r);
                if (n == 2) begin
                    // Hand-typed samples replace the shadow decoder's values.
                    if (kp.known) begin
                        hi_r.pcm = kp.hi;
                        lo_r.pcm = kp.lo;
                    end
                    samples_due.push_back(hi_r);
                    samples_due.push_back(lo_r);
                end
            end
        end
    end

    // Receiver: holds tready low in random bursts.
    always @(posedge i_clk) begin
        if (calm_tail) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one byte, possibly after a short idle burst, and returns at the
    // edge that accepts it. The sender leaves tvalid high for a following byte.
    task automatic send_byte(input logic [BYTE_W-1:0] din, input bit clear,
                             input bit known, input int hi, input int lo);
        t_known_pair kp;
        kp.known = known;
        kp.hi    = PCM_W'(hi);
        kp.lo    = PCM_W'(lo);
        if (gaps_on && !calm_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        known_due.push_back(kp);
        s_axis_tdata  <= din;
        s_axis_tuser  <= clear;
        s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Stops offering bytes and waits until every sample has arrived and the
    // work stage has had time to finish a trailing scale byte.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (samples_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges once the decoder is quiet.
    task automatic load_settings(input int cr, input int co, input int bb, input int nch);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COEF_RECENT;
        i_cfg_data <= CFG_DATA_W'(COEF_RECENT_W'(cr));
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COEF_OLDER;
        i_cfg_data <= CFG_DATA_W'(COEF_OLDER_W'(co));
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BLOCK_BYTES;
        i_cfg_data <= CFG_DATA_W'(BLOCK_BYTES_W'(bb));
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CHAN_USED;
        i_cfg_data <= CFG_DATA_W'(CHAN_USED_W'(nch));
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int sent;
        int n_items;
        int cr;
        int co;
        int bb;
        int nch;
        sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        foreach (dir_tab[i]) begin
            case (dir_tab[i].kind)
                ROW_CFG: begin
                    load_settings(dir_tab[i].f0, dir_tab[i].f1, dir_tab[i].f2, dir_tab[i].f3);
                end
                ROW_KNOWN: begin
                    send_byte(BYTE_W'(dir_tab[i].f0), dir_tab[i].f1 != 0, 1'b1,
                              dir_tab[i].f2, dir_tab[i].f3);
                end
                default: begin
                    send_byte(BYTE_W'(dir_tab[i].f0), dir_tab[i].f1 != 0, 1'b0, 0, 0);
                end
            endcase
        end

        // Random phases. The stream carries on across register changes, so a
        // new block size or channel count often lands in the middle of a block.
        // Once the calm tail has begun the settings stay as they are, so the
        // stream is not paused again.
        while (sent < RAND_ITEMS) begin
            if (!calm_tail) begin
                case ($urandom_range(0, 5))
                    0:       cr = 0;
                    1:       cr = 8192;
                    2:       cr = $urandom_range(0, 16383);
                    default: cr = $urandom_range(0, 8192);
                endcase
                case ($urandom_range(0, 5))
                    0:       co = 0;
                    1:       co = -4096;
                    2:       co = int'($urandom_range(0, 8191)) - 4096;
                    default: co = -int'($urandom_range(0, 4096));
                endcase
                case ($urandom_range(0, 7))
                    0:       bb = $urandom_range(0, 2);
                    1:       bb = 255;
                    2:       bb = 3;
                    3:       bb = $urandom_range(3, 255);
                    default: bb = $urandom_range(3, 24);
                endcase
                nch = $urandom_range(0, 3);
                load_settings(cr, co, bb, nch);

                gaps_on = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end

            n_items = $urandom_range(20, 120);
            for (int k = 0; k < n_items && sent < RAND_ITEMS; k++) begin
                if (sent >= RAND_ITEMS - CALM_ITEMS) begin
                    calm_tail = 1'b1;
                end
                send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 39) == 0,
                          1'b0, 0, 0);
                sent++;
            end
        end

        wait_quiet();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
